// File: design/moe_topk_expert_router_top_assert.svh
// ---------------------------------------------------------------------------
// moe top-k expert router assertion macros
// shared property wrappers, clocked on clk and disabled during reset
// ---------------------------------------------------------------------------
`ifndef MOE_TOPK_EXPERT_ROUTER_TOP_ASSERT_SVH
`define MOE_TOPK_EXPERT_ROUTER_TOP_ASSERT_SVH

// same-cycle implication
`define RTR_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/moe_rtr_pkg.sv
// ---------------------------------------------------------------------------
// moe router package
// field widths, register codes, chain and divider types, sigmoid table build
// ---------------------------------------------------------------------------
package moe_rtr_pkg;

    localparam int LOGIT_W    = 16;
    localparam int BIAS_W     = 20;
    localparam int KEY_W      = 21;
    localparam int PROB_W     = 16;
    localparam int SCALE_W    = 16;
    localparam int FIRST_W    = 8;
    localparam int OWNED_W    = 9;
    localparam int EIDX_W     = 8;
    localparam int WEIGHT_W   = 16;
    localparam int PRODUCT_W  = PROB_W + SCALE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 32;

    localparam int MAX_EXPERTS_DEFAULT = 256;
    localparam int TOP_K_DEFAULT       = 8;

    localparam int LOGIT_CLAMP = 2048;
    localparam int SIG_DEPTH   = LOGIT_CLAMP + 1;
    localparam int SIG_ADDR_W  = $clog2(SIG_DEPTH);
    localparam int MIN_SUM     = 4;
    localparam int TAYLOR_TERMS = 28;

    localparam logic [PROB_W-1:0]  PROB_MAX    = '1;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd11579;
    localparam logic [FIRST_W-1:0] FIRST_RESET = 8'd32;
    localparam logic [OWNED_W-1:0] OWNED_RESET = 9'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_SCALE = 2'd0,
        REG_FIRST_OWNED  = 2'd1,
        REG_OWNED_COUNT  = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        logic                     valid;
        logic signed [KEY_W-1:0]  key;
        logic [PROB_W-1:0]        prob;
    } slot_t;

    typedef struct packed {
        logic start;
        logic ack;
    } div_ctl_t;

    typedef struct packed {
        logic                done;
        logic [WEIGHT_W-1:0] quotient;
    } div_rsp_t;

    typedef logic [PROB_W-1:0] sig_rom_t [SIG_DEPTH];

    // round(65535 / (1 + exp(-a/256))) for a in 0..2048, fixed point
    function automatic logic [PROB_W-1:0] sig_entry(input logic [SIG_ADDR_W-1:0] a);
        logic [63:0]  a64;
        logic [63:0]  term;
        logic [63:0]  pos;
        logic [63:0]  neg;
        logic [63:0]  hi;
        logic [63:0]  lo;
        logic [63:0]  g;
        logic [63:0]  y;
        logic [127:0] prod;
        logic [63:0]  d;
        logic [63:0]  rem;
        logic [63:0]  q;
        logic [63:0]  v;
        logic [76:0]  num;
        int           n;
        int           i;
        a64  = 64'(a);
        term = 64'd1 << 60;
        pos  = 64'd1 << 60;
        neg  = '0;
        for (n = 1; n <= TAYLOR_TERMS; n++)
        begin
            hi   = term >> 11;
            lo   = term & 64'd2047;
            term = (hi * a64 + ((lo * a64) >> 11)) / 64'(n);
            if (n % 2 == 1)
            begin
                neg = neg + term;
            end
            else
            begin
                pos = pos + term;
            end
        end
        g    = pos - neg;
        prod = {64'd0, g} * {64'd0, g};
        y    = 64'(prod >> 60);
        prod = {64'd0, y} * {64'd0, y};
        y    = 64'(prod >> 60);
        prod = {64'd0, y} * {64'd0, y};
        y    = 64'(prod >> 60);
        d    = (64'd1 << 60) + y;
        num  = 77'(PROB_MAX) << 61;
        rem  = '0;
        q    = '0;
        for (i = 76; i >= 0; i--)
        begin
            rem = (rem << 1) | 64'(num[i]);
            q   = q << 1;
            if (rem >= d)
            begin
                rem = rem - d;
                q   = q | 64'd1;
            end
        end
        v = (q + 64'd1) >> 1;
        if (v > 64'(PROB_MAX))
        begin
            v = 64'(PROB_MAX);
        end
        return v[PROB_W-1:0];
    endfunction

    function automatic sig_rom_t build_sig_rom();
        sig_rom_t rom;
        int       k;
        for (k = 0; k < SIG_DEPTH; k++)
        begin
            rom[k] = sig_entry(SIG_ADDR_W'(k));
        end
        return rom;
    endfunction

endpackage

// File: design/moe_topk_expert_router_top.sv
// ---------------------------------------------------------------------------
// moe top-k expert router
// Experts of a token stream in one request per cycle when not draining, in
// index order; each logit goes through a registered sigmoid rom and the key
// p + bias enters a row of TOP_K insertion cells in the next cycle, so
// accumulation runs at one expert per cycle. The request marked tlast closes
// the token: after the s1 register the state moves to ST_LOAD, the cells are
// popped one at a time, largest key first, and each result waits on a
// bit-serial divider for p * scale / max(sum, 4). Input requests are held off
// from the closing request until the last result is produced.
// ---------------------------------------------------------------------------
`include "moe_topk_expert_router_top_assert.svh"

module moe_topk_expert_router_top #(
    parameter int MAX_EXPERTS = moe_rtr_pkg::MAX_EXPERTS_DEFAULT,
    parameter int TOP_K       = moe_rtr_pkg::TOP_K_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [moe_rtr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [moe_rtr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // gate_logit, selection_bias, zero fill
    input  logic [moe_rtr_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // expert_index, route_weight, local_index
    output logic [moe_rtr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // owned_here
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast
);
    import moe_rtr_pkg::*;

    localparam int IDX_W  = $clog2(MAX_EXPERTS);
    localparam int CNT_W  = $clog2(MAX_EXPERTS + 1);
    localparam int SUM_W  = $clog2(TOP_K * (2 ** PROB_W - 1) + 1);
    localparam int WIDE_W = ((IDX_W > EIDX_W) ? IDX_W : EIDX_W) + 2;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_LOAD,
        ST_CALC
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [SCALE_W-1:0]         scale_reg;
    logic [FIRST_W-1:0]         first_reg;
    logic [OWNED_W-1:0]         owned_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic [SUM_W-1:0]           sum_reg;
    logic [SUM_W-1:0]           sum_next;
    logic                       s1_valid_reg;
    logic                       s1_last_reg;
    logic                       s1_rank_reg;
    logic signed [BIAS_W-1:0]   s1_bias_reg;
    logic [IDX_W-1:0]           s1_idx_reg;
    logic                       out_valid_reg;
    logic [EIDX_W-1:0]          out_eidx_reg;
    logic [WEIGHT_W-1:0]        out_weight_reg;
    logic                       out_own_reg;
    logic [EIDX_W-1:0]          out_local_reg;
    logic                       out_last_reg;

    logic                       in_accept;
    logic                       rank;
    logic [PROB_W-1:0]          prob;
    slot_t                      new_slot;
    cell_op_t                   op;
    logic                       capture;
    logic [SUM_W-1:0]           den;
    logic [SUM_W-1:0]           evict_prob;
    div_ctl_t                   div_ctl;
    div_rsp_t                   div_rsp;
    logic [PRODUCT_W-1:0]       dividend;
    logic [WIDE_W-1:0]          idx_wide;
    logic [WIDE_W-1:0]          first_wide;
    logic [WIDE_W-1:0]          local_wide;
    logic                       own;
    logic [TOP_K-1:0]           cell_valid;
    logic [TOP_K-1:0]           cell_valid_p1;

    slot_t                      chain_slot [TOP_K+1];
    logic [IDX_W-1:0]           chain_idx  [TOP_K+1];
    logic [TOP_K:0]             chain_ins;

    // input side
    assign s_axis_tready = (state_reg == ST_RUN) && !(s1_valid_reg && s1_last_reg);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign rank          = cnt_reg < CNT_W'(MAX_EXPERTS);

    moe_rtr_sig u_sig
    (
        .clk        (clk),
        .en         (in_accept),
        .gate_logit (s_axis_tdata[LOGIT_W-1:0]),
        .prob       (prob)
    );

    assign new_slot.valid = 1'b1;
    assign new_slot.key   = $signed({{(KEY_W - PROB_W){1'b0}}, prob})
                          + $signed({s1_bias_reg[BIAS_W-1], s1_bias_reg});
    assign new_slot.prob  = prob;

    // chain of insertion cells
    assign capture = (state_reg == ST_CALC) && div_rsp.done
                  && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        priority if (s1_valid_reg && s1_rank_reg)
        begin
            op = CELL_INSERT;
        end
        else if (capture)
        begin
            op = CELL_POP;
        end
        else
        begin
            op = CELL_HOLD;
        end
    end

    assign chain_ins[0]      = 1'b0;
    assign chain_slot[TOP_K] = '{valid: 1'b0, key: '0, prob: '0};
    assign chain_idx[TOP_K]  = '0;

    for (genvar gi = 0; gi < TOP_K; gi++)
    begin : g_cell
        slot_t            left_slot;
        logic [IDX_W-1:0] left_idx;

        if (gi == 0)
        begin : g_head
            assign left_slot = new_slot;
            assign left_idx  = s1_idx_reg;
        end
        else
        begin : g_body
            assign left_slot = chain_slot[gi-1];
            assign left_idx  = chain_idx[gi-1];
        end

        moe_rtr_cell #(
            .IDX_W (IDX_W)
        ) u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .new_slot   (new_slot),
            .new_idx    (s1_idx_reg),
            .left_slot  (left_slot),
            .left_idx   (left_idx),
            .left_ins   (chain_ins[gi]),
            .right_slot (chain_slot[gi+1]),
            .right_idx  (chain_idx[gi+1]),
            .slot       (chain_slot[gi]),
            .idx        (chain_idx[gi]),
            .ins        (chain_ins[gi+1])
        );

        assign cell_valid[gi] = chain_slot[gi].valid;
    end

    assign cell_valid_p1 = cell_valid + 1'b1;

    // running sum of kept probabilities
    assign evict_prob = chain_slot[TOP_K-1].valid ? SUM_W'(chain_slot[TOP_K-1].prob) : '0;

    always_comb
    begin
        sum_next = sum_reg;
        priority if (op == CELL_INSERT && chain_ins[TOP_K])
        begin
            sum_next = sum_reg + SUM_W'(prob) - evict_prob;
        end
        else if (state_reg == ST_LOAD && !chain_slot[0].valid)
        begin
            sum_next = '0;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_accept)
        begin
            priority if (s_axis_tlast)
            begin
                cnt_next = '0;
            end
            else if (rank)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (s1_valid_reg && s1_last_reg)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = chain_slot[0].valid ? ST_CALC : ST_RUN;
            end
            ST_CALC:
            begin
                if (capture)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // weight division
    assign den      = (sum_reg < SUM_W'(MIN_SUM)) ? SUM_W'(MIN_SUM) : sum_reg;
    assign dividend = PRODUCT_W'(chain_slot[0].prob) * PRODUCT_W'(scale_reg);

    assign div_ctl.start = (state_reg == ST_LOAD) && chain_slot[0].valid;
    assign div_ctl.ack   = capture;

    moe_rtr_div #(
        .DEN_W (SUM_W)
    ) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (dividend),
        .divisor  (den),
        .rsp      (div_rsp)
    );

    // shard ownership of the popped expert
    assign idx_wide   = WIDE_W'(chain_idx[0]);
    assign first_wide = WIDE_W'(first_reg);
    assign local_wide = idx_wide - first_wide;
    assign own        = (idx_wide >= first_wide) && (local_wide < WIDE_W'(owned_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            scale_reg      <= SCALE_RESET;
            first_reg      <= FIRST_RESET;
            owned_reg      <= OWNED_RESET;
            cnt_reg        <= '0;
            sum_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            s1_rank_reg    <= 1'b0;
            s1_bias_reg    <= '0;
            s1_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_eidx_reg   <= '0;
            out_weight_reg <= '0;
            out_own_reg    <= 1'b0;
            out_local_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            s1_valid_reg <= in_accept;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WEIGHT_SCALE: scale_reg <= cfg_data[SCALE_W-1:0];
                    REG_FIRST_OWNED:  first_reg <= cfg_data[FIRST_W-1:0];
                    REG_OWNED_COUNT:  owned_reg <= cfg_data[OWNED_W-1:0];
                    default:          scale_reg <= scale_reg;
                endcase
            end

            if (in_accept)
            begin
                s1_last_reg <= s_axis_tlast;
                s1_rank_reg <= rank;
                s1_bias_reg <= s_axis_tdata[LOGIT_W +: BIAS_W];
                s1_idx_reg  <= cnt_reg[IDX_W-1:0];
            end

            if (capture)
            begin
                out_valid_reg  <= 1'b1;
                out_eidx_reg   <= idx_wide[EIDX_W-1:0];
                out_weight_reg <= div_rsp.quotient;
                out_own_reg    <= own;
                out_local_reg  <= local_wide[EIDX_W-1:0];
                out_last_reg   <= !chain_slot[1].valid;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_local_reg, out_weight_reg, out_eidx_reg};
    assign m_axis_tuser  = out_own_reg;
    assign m_axis_tlast  = out_last_reg;

    `RTR_ASSERT(a_no_request_in_drain, state_reg != ST_RUN, !s_axis_tready,
        "input request taken while draining")
    `RTR_ASSERT(a_valid_packed, 1'b1, (cell_valid_p1 & cell_valid) == '0,
        "chain valid bits not packed from the head")
    `RTR_ASSERT_NEXT(a_close_starts_drain, s1_valid_reg && s1_last_reg, state_reg == ST_LOAD,
        "closing request did not start the drain")
    `RTR_ASSERT(a_empty_sum_zero, state_reg == ST_RUN && !cell_valid[0], sum_reg == '0,
        "probability sum not cleared with empty chain")
    `RTR_ASSERT(a_pop_valid_head, capture, cell_valid[0],
        "result captured from an empty head cell")

endmodule

// File: design/moe_rtr_sig.sv
// ---------------------------------------------------------------------------
// moe router sigmoid stage
// clamps the logit, reads the sigmoid rom by magnitude, mirrors negatives
// ---------------------------------------------------------------------------
module moe_rtr_sig
(
    input  logic                                    clk,
    input  logic                                    en,
    input  logic signed [moe_rtr_pkg::LOGIT_W-1:0]  gate_logit,
    output logic [moe_rtr_pkg::PROB_W-1:0]          prob
);
    import moe_rtr_pkg::*;

    localparam sig_rom_t SIG_ROM = build_sig_rom();

    logic signed [LOGIT_W-1:0] neg_logit;
    logic [SIG_ADDR_W-1:0]     addr;
    logic [PROB_W-1:0]         mag_reg;
    logic                      neg_reg;

    assign neg_logit = -gate_logit;

    always_comb
    begin
        priority if (gate_logit > LOGIT_CLAMP || gate_logit < -LOGIT_CLAMP)
        begin
            addr = SIG_ADDR_W'(LOGIT_CLAMP);
        end
        else if (gate_logit[LOGIT_W-1])
        begin
            addr = neg_logit[SIG_ADDR_W-1:0];
        end
        else
        begin
            addr = gate_logit[SIG_ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= SIG_ROM[addr];
            neg_reg <= gate_logit[LOGIT_W-1];
        end
    end

    // 1 - s(-x) for negative logits
    assign prob = neg_reg ? ~mag_reg : mag_reg;

endmodule

// File: design/moe_rtr_cell.sv
// ---------------------------------------------------------------------------
// moe router chain cell
// one slot of the sorted top-k chain: hold, insert from left or new, pop right
// ---------------------------------------------------------------------------
module moe_rtr_cell #(
    parameter int IDX_W = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  moe_rtr_pkg::cell_op_t   op,
    input  moe_rtr_pkg::slot_t      new_slot,
    input  logic [IDX_W-1:0]        new_idx,
    input  moe_rtr_pkg::slot_t      left_slot,
    input  logic [IDX_W-1:0]        left_idx,
    input  logic                    left_ins,
    input  moe_rtr_pkg::slot_t      right_slot,
    input  logic [IDX_W-1:0]        right_idx,
    output moe_rtr_pkg::slot_t      slot,
    output logic [IDX_W-1:0]        idx,
    output logic                    ins
);
    import moe_rtr_pkg::*;

    logic                    valid_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [PROB_W-1:0]       prob_reg;
    logic [IDX_W-1:0]        idx_reg;
    slot_t                   slot_next;
    logic [IDX_W-1:0]        idx_next;

    // strict compare keeps the earlier expert ahead on equal keys
    assign ins = !valid_reg || (key_reg < new_slot.key);

    always_comb
    begin
        slot_next = slot;
        idx_next  = idx_reg;
        unique case (op)
            CELL_INSERT:
            begin
                if (ins && left_ins)
                begin
                    slot_next = left_slot;
                    idx_next  = left_idx;
                end
                else if (ins)
                begin
                    slot_next = new_slot;
                    idx_next  = new_idx;
                end
            end
            CELL_POP:
            begin
                slot_next = right_slot;
                idx_next  = right_idx;
            end
            default:
            begin
                slot_next = slot;
                idx_next  = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= slot_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= slot_next.key;
        prob_reg <= slot_next.prob;
        idx_reg  <= idx_next;
    end

    assign slot = '{valid: valid_reg, key: key_reg, prob: prob_reg};
    assign idx  = idx_reg;

endmodule

// File: design/moe_rtr_div.sv
// ---------------------------------------------------------------------------
// moe router weight divider
// restoring divider, one quotient bit per cycle, saturates to 16 bits
// ---------------------------------------------------------------------------
module moe_rtr_div #(
    parameter int DEN_W = 20
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  moe_rtr_pkg::div_ctl_t                ctl,
    input  logic [moe_rtr_pkg::PRODUCT_W-1:0]    dividend,
    input  logic [DEN_W-1:0]                     divisor,
    output moe_rtr_pkg::div_rsp_t                rsp
);
    import moe_rtr_pkg::*;

    localparam int CMP_W  = (DEN_W > WEIGHT_W) ? DEN_W : WEIGHT_W;
    localparam int STEP_W = $clog2(WEIGHT_W);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_DONE
    } div_state_t;

    div_state_t             state_reg;
    logic [DEN_W-1:0]       rem_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [WEIGHT_W-1:0]    low_reg;
    logic [WEIGHT_W-1:0]    quo_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [WEIGHT_W-1:0]    high;
    logic                   sat;
    logic [DEN_W:0]         trial;
    logic [DEN_W:0]         diff;
    logic                   fits;

    assign high  = dividend[PRODUCT_W-1:WEIGHT_W];
    assign sat   = CMP_W'(high) >= CMP_W'(divisor);
    assign trial = {rem_reg, low_reg[WEIGHT_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            rem_reg   <= '0;
            den_reg   <= '0;
            low_reg   <= '0;
            quo_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                D_IDLE:
                begin
                    if (ctl.start)
                    begin
                        den_reg  <= divisor;
                        low_reg  <= dividend[WEIGHT_W-1:0];
                        rem_reg  <= DEN_W'(high);
                        step_reg <= '0;
                        if (sat)
                        begin
                            quo_reg   <= '1;
                            state_reg <= D_DONE;
                        end
                        else
                        begin
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    rem_reg  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    quo_reg  <= {quo_reg[WEIGHT_W-2:0], fits};
                    low_reg  <= low_reg << 1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(WEIGHT_W - 1))
                    begin
                        state_reg <= D_DONE;
                    end
                end
                D_DONE:
                begin
                    if (ctl.ack)
                    begin
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign rsp.done     = (state_reg == D_DONE);
    assign rsp.quotient = quo_reg;

endmodule
